FILE: src/polynomial_term_table_evaluator_top_defines.svh
// Assertion macros for the polynomial term table evaluator.
`ifndef POLYNOMIAL_TERM_TABLE_EVALUATOR_TOP_DEFINES_SVH
`define POLYNOMIAL_TERM_TABLE_EVALUATOR_TOP_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define PTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pte_pkg.sv
// Types, codes and saturation helpers for the polynomial term table evaluator.
`default_nettype none

package pte_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_EVAL  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_PMUL,
    S_TMUL,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic        [3:0]  term_exponent;
    logic signed [31:0] term_coefficient;
    logic signed [31:0] x_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               over;
  } sat_t;

  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Q16.16 product: floor shift by 16, then clamp to 32 bits.
  function automatic sat_t sat_prod(input logic signed [63:0] prod);
    logic signed [63:0] sh;
    sat_t               r;
    sh = prod >>> 16;
    if (sh > 64'sd2147483647) begin
      r.value = S32_MAX;
      r.over  = 1'b1;
    end else if (sh < -64'sd2147483648) begin
      r.value = S32_MIN;
      r.over  = 1'b1;
    end else begin
      r.value = sh[31:0];
      r.over  = 1'b0;
    end
    return r;
  endfunction

  // Clamp a 33-bit sum or difference to 32 bits.
  function automatic sat_t sat_wide(input logic signed [32:0] s);
    sat_t r;
    if (s[32] != s[31]) begin
      r.value = s[32] ? S32_MIN : S32_MAX;
      r.over  = 1'b1;
    end else begin
      r.value = s[31:0];
      r.over  = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/polynomial_term_table_evaluator_top.sv
// Top level of the polynomial term table evaluator with its sequencer and coefficient memory.
//
// Usage: items arrive on the in_valid/in_ready channel as pte_pkg::in_item_t and each
// produces exactly one result on the out_valid/out_ready channel as pte_pkg::out_item_t.
// A transfer happens on a rising edge with valid and ready both high. One item is
// worked on at a time; in_ready is high only while the sequencer waits for work.
// Clear goes from the input transfer to S_DONE; add or subtract passes through S_UPD,
// and evaluate steps S_PMUL and S_TMUL for each slot, then S_ACC. Evaluate relies on the
// single shared 32x32 multiplier, which forms the next power in S_PMUL and the term
// product in S_TMUL for each slot, with the coefficient memory read in S_PMUL ahead of use.
// An item occupies the block until its result is loaded into the output register.
// Results sit in an output register, so a stalled receiver does not stop the next
// item from being taken; a finished result then waits until the register is free.
// Reset (rst, synchronous) empties the pipeline, drops any pending result and marks
// every coefficient slot as zero through per-slot valid bits; clear does the same
// to the valid bits when it is taken. Exponents above MAX_DEGREE leave the table as it
// is and return zero.
`default_nettype none
`include "polynomial_term_table_evaluator_top_defines.svh"

module polynomial_term_table_evaluator_top #(
  parameter int MAX_DEGREE = 15
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pte_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pte_pkg::out_item_t     out_data
);

  localparam int SLOTS = MAX_DEGREE + 1;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_DEGREE);

  pte_pkg::state_t    state, state_next;
  pte_pkg::in_item_t  item, item_next;
  logic [IDX_W-1:0]   slot, slot_next;
  logic signed [31:0] p, p_next;
  logic               p_sat, p_sat_next;
  logic signed [31:0] acc, acc_next;
  logic               flag, flag_next;
  logic               term_nz, term_nz_next;
  logic signed [31:0] res_value, res_value_next;
  logic               res_sat, res_sat_next;
  logic               out_valid_next;
  pte_pkg::out_item_t out_data_next;
  logic [SLOTS-1:0]   slot_valid, slot_valid_next;

  logic signed [31:0] mem [SLOTS];
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] rd_data;
  logic               rd_valid;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_res;
  logic signed [63:0] prod;

  logic signed [31:0] coef_cur;
  logic               coef_nz;
  pte_pkg::sat_t      term_sat, acc_sum, pow_sat, upd_sat;
  logic signed [31:0] acc_upd;
  logic               flag_upd;
  logic               exp_ok;
  logic signed [32:0] upd_wide;

  assign coef_cur = rd_valid ? rd_data : 32'sd0;
  assign coef_nz  = (coef_cur != 32'sd0);
  assign mul_a    = (state == pte_pkg::S_TMUL) ? coef_cur : p;
  assign mul_b    = (state == pte_pkg::S_TMUL) ? p : item.x_value;
  assign mul_res  = mul_a * mul_b;

  assign term_sat = pte_pkg::sat_prod(prod);
  assign pow_sat  = pte_pkg::sat_prod(prod);
  assign acc_sum  = pte_pkg::sat_wide({acc[31], acc} + {term_sat.value[31], term_sat.value});
  assign acc_upd  = term_nz ? acc_sum.value : acc;
  assign flag_upd = flag | (term_nz & (term_sat.over | acc_sum.over));

  assign exp_ok   = (32'(item.term_exponent) < SLOTS);
  assign upd_wide = (item.operation == pte_pkg::OP_ADD)
                    ? ({coef_cur[31], coef_cur} + {item.term_coefficient[31],
                                                   item.term_coefficient})
                    : ({coef_cur[31], coef_cur} - {item.term_coefficient[31],
                                                   item.term_coefficient});
  assign upd_sat  = pte_pkg::sat_wide(upd_wide);

  always_comb begin
    state_next      = state;
    item_next       = item;
    slot_next       = slot;
    p_next          = p;
    p_sat_next      = p_sat;
    acc_next        = acc;
    flag_next       = flag;
    term_nz_next    = term_nz;
    res_value_next  = res_value;
    res_sat_next    = res_sat;
    slot_valid_next = slot_valid;
    out_valid_next  = out_valid & ~out_ready;
    out_data_next   = out_data;
    in_ready        = 1'b0;
    rd_addr         = IDX_W'(in_data.term_exponent);
    wr_en           = 1'b0;
    wr_addr         = IDX_W'(item.term_exponent);
    wr_data         = upd_sat.value;

    unique case (state)
      pte_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next = in_data;
          unique case (in_data.operation)
            pte_pkg::OP_ADD, pte_pkg::OP_SUB: begin
              state_next = pte_pkg::S_UPD;
            end
            pte_pkg::OP_EVAL: begin
              p_next       = pte_pkg::Q_ONE;
              p_sat_next   = 1'b0;
              acc_next     = 32'sd0;
              flag_next    = 1'b0;
              term_nz_next = 1'b0;
              slot_next    = '0;
              state_next   = pte_pkg::S_PMUL;
            end
            pte_pkg::OP_CLEAR: begin
              slot_valid_next = '0;
              res_value_next  = 32'sd0;
              res_sat_next    = 1'b0;
              state_next      = pte_pkg::S_DONE;
            end
          endcase
        end
      end
      pte_pkg::S_UPD: begin
        if (exp_ok) begin
          wr_en                    = 1'b1;
          slot_valid_next[wr_addr] = 1'b1;
          res_value_next           = upd_sat.value;
          res_sat_next             = upd_sat.over;
        end else begin
          res_value_next = 32'sd0;
          res_sat_next   = 1'b0;
        end
        state_next = pte_pkg::S_DONE;
      end
      pte_pkg::S_PMUL: begin
        rd_addr    = slot;
        acc_next   = acc_upd;
        flag_next  = flag_upd;
        state_next = pte_pkg::S_TMUL;
      end
      pte_pkg::S_TMUL: begin
        p_next       = pow_sat.value;
        p_sat_next   = p_sat | pow_sat.over;
        term_nz_next = coef_nz;
        flag_next    = flag | (coef_nz & p_sat);
        if (slot == LAST_SLOT) begin
          state_next = pte_pkg::S_ACC;
        end else begin
          slot_next  = slot + 1'b1;
          state_next = pte_pkg::S_PMUL;
        end
      end
      pte_pkg::S_ACC: begin
        res_value_next = acc_upd;
        res_sat_next   = flag_upd;
        state_next     = pte_pkg::S_DONE;
      end
      pte_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next             = 1'b1;
          out_data_next.result_value = res_value;
          out_data_next.saturated    = res_sat;
          state_next                 = pte_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pte_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pte_pkg::S_IDLE;
      out_valid  <= 1'b0;
      slot_valid <= '0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item      <= item_next;
    slot      <= slot_next;
    p         <= p_next;
    p_sat     <= p_sat_next;
    acc       <= acc_next;
    flag      <= flag_next;
    term_nz   <= term_nz_next;
    res_value <= res_value_next;
    res_sat   <= res_sat_next;
    out_data  <= out_data_next;
    prod      <= mul_res;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data  <= mem[rd_addr];
    rd_valid <= slot_valid[rd_addr];
  end

  `PTE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")
  `PTE_ASSERT_NEXT(a_done_loads, (state == pte_pkg::S_DONE) && (!out_valid || out_ready),
                   out_valid, "finished result not presented")
  `PTE_ASSERT_NEXT(a_clear_empties,
                   in_valid && in_ready && (in_data.operation == pte_pkg::OP_CLEAR),
                   slot_valid == '0, "clear left slots marked valid")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the polynomial term table evaluator: directed table then random.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DEGREE  = 15;
  localparam int SLOT_COUNT  = MAX_DEGREE + 1;
  localparam int TOTAL_ITEMS = 1175;
  localparam int DRAIN       = 2 * SLOT_COUNT + 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    pte_pkg::in_item_t  item;
    bit                 typed;
    pte_pkg::out_item_t want;
  } vector_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  pte_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  pte_pkg::out_item_t out_data;

  logic signed [31:0] coeff_slots [SLOT_COUNT];
  pte_pkg::out_item_t pending_results [$];
  vector_row_t        directed_rows [$];
  int                 mismatch_count;
  int                 sent_items;
  int                 cycle_count;
  bit                 steady;
  pte_pkg::in_item_t  stim;

  polynomial_term_table_evaluator_top #(
    .MAX_DEGREE(MAX_DEGREE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [32:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end
    if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] q_mul(input longint a, input longint b);
    longint prod;
    prod = a * b;
    return clamp32(prod >>> 16);
  endfunction

  function automatic pte_pkg::out_item_t apply_term_item(input pte_pkg::in_item_t it);
    pte_pkg::out_item_t r;
    logic [32:0]        step;
    longint             acc;
    longint             pw;
    longint             xv;
    logic               pw_over;
    r   = '0;
    acc = 0;
    pw  = 65536;
    pw_over = 1'b0;
    xv  = longint'(it.x_value);
    case (it.operation)
      pte_pkg::OP_ADD, pte_pkg::OP_SUB: begin
        if (int'(it.term_exponent) <= MAX_DEGREE) begin
          if (it.operation == pte_pkg::OP_ADD) begin
            step = clamp32(longint'(coeff_slots[it.term_exponent]) +
                           longint'(it.term_coefficient));
          end else begin
            step = clamp32(longint'(coeff_slots[it.term_exponent]) -
                           longint'(it.term_coefficient));
          end
          coeff_slots[it.term_exponent] = step[31:0];
          r.result_value = step[31:0];
          r.saturated    = step[32];
        end
      end
      pte_pkg::OP_EVAL: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (coeff_slots[i] != 0) begin
            if (pw_over) r.saturated = 1'b1;
            step = q_mul(longint'(coeff_slots[i]), pw);
            r.saturated = r.saturated | step[32];
            step = clamp32(acc + longint'($signed(step[31:0])));
            r.saturated = r.saturated | step[32];
            acc = longint'($signed(step[31:0]));
          end
          if (i + 1 < SLOT_COUNT) begin
            step = q_mul(pw, xv);
            pw_over = pw_over | step[32];
            pw = longint'($signed(step[31:0]));
          end
        end
        r.result_value = acc[31:0];
      end
      default: begin
        for (int i = 0; i < SLOT_COUNT; i++) coeff_slots[i] = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] pick_coefficient();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r;
      1: return {{13{r[18]}}, r[18:0]};
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0001;
          3: return -32'sh0000_0001;
          default: return pte_pkg::Q_ONE;
        endcase
      end
      default: return {{15{r[16]}}, r[16:0]};
    endcase
  endfunction

  function automatic logic signed [31:0] pick_point();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return r;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return -pte_pkg::Q_ONE;
          default: return pte_pkg::Q_ONE;
        endcase
      end
      2, 3, 4: return {{14{r[17]}}, r[17:0]};
      default: return {{15{r[16]}}, r[16:0]};
    endcase
  endfunction

  function automatic void add_row(input pte_pkg::op_t op, input logic [3:0] e,
                                  input logic [31:0] c, input logic [31:0] x,
                                  input bit typed, input logic [31:0] res,
                                  input logic sat);
    vector_row_t row;
    row.item.operation        = op;
    row.item.term_exponent    = e;
    row.item.term_coefficient = c;
    row.item.x_value          = x;
    row.typed                 = typed;
    row.want.result_value     = res;
    row.want.saturated        = sat;
    directed_rows = {directed_rows, row};
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic send_item(input pte_pkg::in_item_t it, input bit use_typed,
                           input pte_pkg::out_item_t typed_want);
    pte_pkg::out_item_t predicted;
    pte_pkg::out_item_t queued;
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_term_item(it);
    queued    = use_typed ? typed_want : predicted;
    pending_results = {pending_results, queued};
    sent_items++;
    steady = (sent_items >= 400) && (sent_items < 650);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk) begin
    pte_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          report_mismatch($sformatf("result_value %h, expected %h",
                                    out_data.result_value, want.result_value));
        end
        if (out_data.saturated !== want.saturated) begin
          report_mismatch($sformatf("saturated %b, expected %b",
                                    out_data.saturated, want.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    bit paused_once;
    paused_once    = 1'b0;
    mismatch_count = 0;
    sent_items     = 0;
    cycle_count    = 0;
    steady         = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) coeff_slots[i] = '0;

    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'h0001_0000, 1, 32'h0000_0000, 1'b0);
    add_row(pte_pkg::OP_ADD,   4'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1, 32'h7FFF_FFFF, 1'b0);
    add_row(pte_pkg::OP_ADD,   4'd0,  32'h0000_0001, 32'h0000_0000, 1, 32'h7FFF_FFFF, 1'b1);
    add_row(pte_pkg::OP_SUB,   4'd1,  32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 1'b1);
    add_row(pte_pkg::OP_SUB,   4'd2,  32'h0000_0001, 32'h0000_0000, 1, 32'hFFFF_FFFF, 1'b0);
    add_row(pte_pkg::OP_ADD,   4'd15, 32'h0001_0000, 32'h0000_0000, 1, 32'h0001_0000, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'h7FFF_FFFF, 0, '0, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd15, 32'hFFFF_FFFF, 32'h8000_0000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'h0000_0000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_CLEAR, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0000, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1, 32'h0000_0000, 1'b0);
    add_row(pte_pkg::OP_ADD,   4'd3,  32'h8000_0000, 32'h0000_0000, 1, 32'h8000_0000, 1'b0);
    add_row(pte_pkg::OP_SUB,   4'd3,  32'h0000_0001, 32'h0000_0000, 1, 32'h8000_0000, 1'b1);
    add_row(pte_pkg::OP_ADD,   4'd1,  32'h0002_0000, 32'h0000_0000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_ADD,   4'd0,  32'hFFFF_8000, 32'h0000_0000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'h0001_0000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'hFFFF_0000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'h0000_8000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_EVAL,  4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 0, '0, 1'b0);
    add_row(pte_pkg::OP_SUB,   4'd3,  32'h8000_0000, 32'h0000_0000, 0, '0, 1'b0);
    add_row(pte_pkg::OP_CLEAR, 4'd0,  32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    while (sent_items < TOTAL_ITEMS) begin
      if (!paused_once && sent_items >= 800) begin
        paused_once = 1'b1;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        stim.operation        = pte_pkg::op_t'($urandom_range(0, 3));
        stim.term_exponent    = 4'($urandom);
        stim.term_coefficient = $urandom;
        stim.x_value          = $urandom;
        send_item(stim, 1'b0, '0);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          stim.operation        = pte_pkg::OP_CLEAR;
          stim.term_exponent    = 4'($urandom);
          stim.term_coefficient = $urandom;
          stim.x_value          = $urandom;
          send_item(stim, 1'b0, '0);
        end
        repeat ($urandom_range(1, 6)) begin
          stim.operation        = ($urandom_range(0, 2) != 0) ? pte_pkg::OP_ADD
                                                               : pte_pkg::OP_SUB;
          stim.term_exponent    = 4'($urandom_range(0, MAX_DEGREE));
          stim.term_coefficient = pick_coefficient();
          stim.x_value          = $urandom;
          send_item(stim, 1'b0, '0);
        end
        repeat ($urandom_range(1, 3)) begin
          stim.operation        = pte_pkg::OP_EVAL;
          stim.term_exponent    = 4'($urandom);
          stim.term_coefficient = $urandom;
          stim.x_value          = pick_point();
          send_item(stim, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/pte_pkg.sv
src/polynomial_term_table_evaluator_top.sv
sim/testbench.sv
